// ===== sv/ubxp_pkg.sv =====
package ubxp_pkg;

  // Sync pattern that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Reset value of the maximum payload length register
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // Result kinds
  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_GOOD   = 2'd1,
    EV_CKSUM  = 2'd2,
    EV_LENGTH = 2'd3
  } event_t;

  // One result item
  typedef struct packed {
    event_t      ev;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

// ===== sv/ubx_frame_parser.sv =====
// Channel | Dir | Signals                         | Contents
// in_     | in  | in_tvalid/tready/tdata[7:0]     | one received byte
// out_    | out | out_tvalid/tready/tdata/tuser   | payload byte or frame event
// cfg_    | in  | cfg_wr_en, cfg_wr_data[15:0]    | maximum payload length
//
// One byte per cycle, unless a byte with a result meets a stalled output. A byte
// is held in the input register and its result, if any, is loaded into the
// output register when the byte moves on. Synchronous active-low reset returns
// the parser to sync hunting and sets the length limit to 1024. A stalled result
// holds back only a byte that has a result of its own; bytes without one keep
// moving through the input register.
module ubx_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [7:0] msg_class, [15:8] msg_id,
                                   // [31:16] payload_length, [47:32] byte_index,
                                   // [55:48] payload_byte
  output logic [1:0]  out_tuser,   // [1:0] event_res
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import ubxp_pkg::*;

  logic [15:0] max_len_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  result_t     out_res_r;

  logic        has_res;
  result_t     res;
  logic        advance;

  // Held byte moves on unless its result is blocked by a stalled output
  assign advance   = in_valid_r && (!has_res || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ubxp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .max_len (max_len_r),
    .has_res (has_res),
    .res     (res)
  );

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ev;
  assign out_tdata  = {out_res_r.payload_byte, out_res_r.byte_index,
                       out_res_r.payload_length, out_res_r.msg_id,
                       out_res_r.msg_class};

endmodule

// ===== sv/ubxp_core.sv =====
module ubxp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,      // consume rx_byte this cycle
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       max_len,
  output logic              has_res,   // rx_byte produces a result
  output ubxp_pkg::result_t res
);
  import ubxp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC1, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CK_B
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;

  // Fletcher running sums with the current byte folded in
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;

  assign add_a    = sum_a_r + rx_byte;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {rx_byte, len_r[7:0]};

  // Next state and result decode
  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    has_res   = 1'b0;
    res.ev             = EV_DATA;
    res.msg_class      = class_r;
    res.msg_id         = id_r;
    res.payload_length = len_r;
    res.byte_index     = '0;
    res.payload_byte   = '0;
    unique case (phase_r)
      PH_HUNT: begin
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
      end
      PH_SYNC1: begin
        phase_nxt = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = rx_byte;
        sum_b_nxt = rx_byte;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, rx_byte};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        cnt_nxt   = '0;
        res.payload_length = len_full;
        if (len_full > max_len) begin
          has_res   = 1'b1;
          res.ev    = EV_LENGTH;
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (cnt_r < len_r) begin
          // payload byte
          sum_a_nxt        = add_a;
          sum_b_nxt        = add_b;
          cnt_nxt          = cnt_r + 16'd1;
          has_res          = 1'b1;
          res.ev           = EV_DATA;
          res.byte_index   = cnt_r;
          res.payload_byte = rx_byte;
        end else if (rx_byte == sum_a_r) begin
          phase_nxt = PH_CK_B;
        end else begin
          has_res   = 1'b1;
          res.ev    = EV_CKSUM;
          phase_nxt = PH_HUNT;
        end
      end
      PH_CK_B: begin
        has_res   = 1'b1;
        res.ev    = (rx_byte == sum_b_r) ? EV_GOOD : EV_CKSUM;
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

endmodule

// ===== test/ubx_frame_checker.sv =====
`timescale 1ns / 100ps
module ubx_frame_checker
  import ubxp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,   // [7:0] msg_class, [15:8] msg_id,
                                   // [31:16] payload_length, [47:32] byte_index,
                                   // [55:48] payload_byte
  input  logic [1:0]  out_tuser,   // [1:0] event_res
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  // Deframer phases of the shadow parser
  typedef enum logic [2:0] {
    P_HUNT,
    P_SYNC_SEEN,
    P_CLASS,
    P_ID,
    P_LEN_LO,
    P_LEN_HI,
    P_PAYLOAD,
    P_CK_B
  } phase_t;

  phase_t      phase;
  logic [7:0]  cls_q;
  logic [7:0]  id_q;
  logic [15:0] len_q;
  logic [15:0] count_q;
  logic [15:0] limit_q;
  logic [7:0]  ck_a;
  logic [7:0]  ck_b;

  result_t expected_events[$];
  int      mismatches = 0;
  int      waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  task automatic add_to_fletcher(input logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endtask

  task automatic queue_event(input event_t ev, input logic [15:0] idx,
                             input logic [7:0] data);
    result_t r;
    r.ev             = ev;
    r.msg_class      = cls_q;
    r.msg_id         = id_q;
    r.payload_length = len_q;
    r.byte_index     = idx;
    r.payload_byte   = data;
    expected_events.push_back(r);
  endtask

  // Advance the shadow parser by one received byte
  task automatic track_rx_byte(input logic [7:0] b);
    case (phase)
      P_HUNT: begin
        phase = (b == SYNC_FIRST) ? P_SYNC_SEEN : P_HUNT;
      end
      P_SYNC_SEEN: begin
        // a bad second sync is not retried as a first sync
        phase = (b == SYNC_SECOND) ? P_CLASS : P_HUNT;
      end
      P_CLASS: begin
        cls_q = b;
        ck_a  = b;
        ck_b  = b;
        phase = P_ID;
      end
      P_ID: begin
        id_q = b;
        add_to_fletcher(b);
        phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        len_q = {8'h00, b};
        add_to_fletcher(b);
        phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        len_q[15:8] = b;
        add_to_fletcher(b);
        if (len_q > limit_q) begin
          queue_event(EV_LENGTH, 16'd0, 8'd0);
          phase = P_HUNT;
        end else begin
          count_q = 16'd0;
          phase   = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        if (count_q < len_q) begin
          queue_event(EV_DATA, count_q, b);
          add_to_fletcher(b);
          count_q = count_q + 16'd1;
        end else if (b == ck_a) begin
          phase = P_CK_B;
        end else begin
          queue_event(EV_CKSUM, 16'd0, 8'd0);
          phase = P_HUNT;
        end
      end
      default: begin
        queue_event((b == ck_b) ? EV_GOOD : EV_CKSUM, 16'd0, 8'd0);
        phase = P_HUNT;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare output transfers, then track input transfers and register writes
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase   = P_HUNT;
      cls_q   = 8'd0;
      id_q    = 8'd0;
      len_q   = 16'd0;
      count_q = 16'd0;
      ck_a    = 8'd0;
      ck_b    = 8'd0;
      limit_q = MAX_LEN_RESET;
      expected_events.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          $error("result transfer with none expected: event %0d", out_tuser);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 16'(want.ev), 16'(out_tuser));
          check_field("msg_class", 16'(want.msg_class), 16'(out_tdata[7:0]));
          check_field("msg_id", 16'(want.msg_id), 16'(out_tdata[15:8]));
          check_field("payload_length", want.payload_length, out_tdata[31:16]);
          check_field("byte_index", want.byte_index, out_tdata[47:32]);
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_tdata[55:48]));
        end
      end
      if (in_tvalid && in_tready) track_rx_byte(in_tdata);
      if (cfg_wr_en) limit_q = cfg_wr_data;
    end
    waiting = expected_events.size();
  end

endmodule

// ===== test/tb_ubx_frame_parser.sv =====
`timescale 1ns / 100ps
module tb_ubx_frame_parser;
  import ubxp_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int BYTES_PER_PHASE = 240;
  localparam int DRAIN_CYCLES    = 4;

  typedef enum {FRAME_OK, BAD_CK_A, BAD_CK_B} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          frame_bytes = 0;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;
  bit          sender_gaps = 1'b1;
  logic [15:0] cur_limit = MAX_LEN_RESET;
  logic [7:0]  run_a;
  logic [7:0]  run_b;

  always #1 clk = ~clk;

  ubx_frame_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  ubx_frame_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold on request, none at the end
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                            : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // One byte transfer, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (sender_gaps && !calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_summed(input logic [7:0] b);
    send_byte(b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endtask

  // Full frame; header only when the length is over the limit
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input frame_kind_t kind);
    logic [7:0] ck;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    run_a = 8'd0;
    run_b = 8'd0;
    send_summed(cls);
    send_summed(id);
    send_summed(len[7:0]);
    send_summed(len[15:8]);
    frame_bytes += 6;
    if (len <= cur_limit) begin
      for (int i = 0; i < int'(len); i++) send_summed(8'($urandom_range(0, 255)));
      ck = run_a;
      if (kind == BAD_CK_A) ck = ck ^ 8'($urandom_range(1, 255));
      send_byte(ck);
      ck = run_b;
      if (kind == BAD_CK_B) ck = ck ^ 8'($urandom_range(1, 255));
      send_byte(ck);
      frame_bytes += int'(len) + 2;
    end
  endtask

  // Bytes between frames: a broken sync pair or stray bytes
  task automatic send_noise();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) begin
      send_byte(SYNC_FIRST);
      b = 8'($urandom_range(0, 255));
      if (b == SYNC_SECOND) b = SYNC_FIRST;
      send_byte(b);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_FIRST) b = 8'h00;
        send_byte(b);
      end
    end
  endtask

  // Stop offering and let every result drain out of the pipeline
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = value;
  endtask

  // Mostly well-formed frames with random content, some noise
  task automatic random_phase(input logic [15:0] value);
    int          lim;
    int          k;
    int          c;
    logic [15:0] len;
    frame_kind_t kind;
    write_limit(value);
    lim = int'(value);
    frame_bytes = 0;
    while (frame_bytes < BYTES_PER_PHASE) begin
      sender_gaps = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 2) begin
        send_noise();
      end else begin
        k = $urandom_range(0, 49);
        if (k < 5 && lim != 65535)
          len = 16'((k == 0) ? lim + 1 : $urandom_range(lim + 1, 65535));
        else if (k < 8)
          len = 16'((lim < 24) ? lim : $urandom_range(0, 24));
        else if (k == 8 && lim >= 300)
          len = 16'($urandom_range(100, 300));
        else
          len = 16'($urandom_range(0, (lim < 12) ? lim : 12));
        c = $urandom_range(0, 9);
        kind = (c == 0) ? BAD_CK_A : (c == 1) ? BAD_CK_B : FRAME_OK;
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, kind);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases at the reset limit
    send_frame(8'h00, 8'h00, 16'd0, FRAME_OK);
    send_frame(8'hFF, 8'hFF, 16'd4, FRAME_OK);
    // broken second sync: the repeated first sync must not restart the frame
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_frame(8'h01, 8'h07, 16'd2, FRAME_OK);
    send_frame(8'h05, 8'h01, 16'd0, BAD_CK_A);
    send_frame(8'h0A, 8'h04, 16'd3, BAD_CK_B);
    send_frame(8'h02, 8'h15, MAX_LEN_RESET + 16'd1, FRAME_OK);
    send_frame(8'h03, 8'h0A, 16'hFFFF, FRAME_OK);

    // widest limit, opened by a long output hold that backs up the input
    write_limit(16'hFFFF);
    long_hold = 1'b1;
    in_tvalid <= 1'b0;
    while (long_hold) @(posedge clk);
    sender_gaps = 1'b0;
    send_frame(8'h01, 8'h02, 16'd40, FRAME_OK);
    random_phase(16'hFFFF);

    random_phase(16'd0);
    random_phase(16'($urandom_range(1, 20)));
    random_phase(16'($urandom_range(0, 65535)));
    random_phase(16'd1024);

    // last stretch runs without idling on either side
    calm = 1'b1;
    random_phase(16'($urandom_range(0, 30)));

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
